@@ hw/rtl/rars_pkg.sv @@
// ----------------------------------------------------------------------------
// rars_pkg
// Shared constants and controller/datapath interface types for the
// range add / range sum store.
// ----------------------------------------------------------------------------
package rars_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int LEN_W        = IDX_W + 1;
   localparam int POS_W        = IDX_W + 2;
   localparam int DATA_W       = 32;
   localparam int WORD_W       = 2 * DATA_W;

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic load;
      logic prep;
      logic upd;
      logic mul;
      logic acc;
      logic clr_start;
      logic clr_step;
      logic phase;
   } cmd_type;

   typedef struct packed {
      logic ok;
      logic is_query;
      logic pos_valid;
      logic clr_last;
   } status_type;

endpackage

@@ hw/rtl/rars_ram.sv @@
// ----------------------------------------------------------------------------
// rars_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rars_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/rars_datapath.sv @@
// ----------------------------------------------------------------------------
// rars_datapath
// Two interleaved binary indexed trees (linear and index-weighted deltas)
// held in one RAM, with the walk position, accumulators and result.
// ----------------------------------------------------------------------------
module rars_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  rars_pkg::cmd_type                  cmd,
   output rars_pkg::status_type               status,
   input  logic                               csr_wr_en,
   input  logic [rars_pkg::LEN_W-1:0]         csr_wr_data,
   input  logic                               req_type,
   input  logic [rars_pkg::IDX_W-1:0]         req_left_index,
   input  logic [rars_pkg::IDX_W-1:0]         req_right_index,
   input  logic signed [rars_pkg::DATA_W-1:0] req_add_value,
   output logic signed [rars_pkg::DATA_W-1:0] rsp_range_sum
);
   import rars_pkg::*;

   logic [LEN_W-1:0]  len_ff;
   logic [IDX_W-1:0]  clr_cnt_ff;
   logic              is_query_ff, ok_ff;
   logic [LEN_W-1:0]  a_ff, b_ff;
   logic [DATA_W-1:0] v_ff, d1_ff, d2_ff, s1_ff, s2_ff, prod_ff, total_ff;
   logic [POS_W-1:0]  pos_ff;

   logic [LEN_W-1:0]  len_in, r_plus, b_in, a_minus;
   logic              ok_in;
   logic [POS_W-1:0]  lowbit;
   logic [WORD_W-1:0] rd_data, wr_data;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic              wr_en;
   logic [DATA_W-1:0] k_mul, prod_in, diff;

   always_comb begin
      len_in = csr_wr_data;
      if (csr_wr_data == '0) begin
         len_in = LEN_W'(1);
      end else if (csr_wr_data > LEN_W'(MAX_ELEMENTS)) begin
         len_in = LEN_W'(MAX_ELEMENTS);
      end
   end

   assign ok_in   = (req_left_index <= req_right_index) &&
                    ({1'b0, req_left_index} < len_ff);
   assign r_plus  = {1'b0, req_right_index} + LEN_W'(1);
   assign b_in    = (r_plus > len_ff) ? len_ff : r_plus;
   assign a_minus = a_ff - LEN_W'(1);
   assign lowbit  = pos_ff & (~pos_ff + POS_W'(1));
   assign k_mul   = cmd.phase ? DATA_W'(a_minus) : DATA_W'(b_ff);
   assign prod_in = s1_ff * k_mul;
   assign diff    = prod_ff - s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= LEN_W'(MAX_ELEMENTS);
         clr_cnt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            len_ff <= len_in;
         end
         if (cmd.clr_start) begin
            clr_cnt_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_query_ff <= req_type;
         ok_ff       <= ok_in;
         a_ff        <= {1'b0, req_left_index} + LEN_W'(1);
         b_ff        <= b_in;
         v_ff        <= req_add_value;
         total_ff    <= '0;
      end
      if (cmd.prep) begin
         s1_ff <= '0;
         s2_ff <= '0;
         if (!cmd.phase) begin
            pos_ff <= is_query_ff ? POS_W'(b_ff) : POS_W'(a_ff);
            d1_ff  <= v_ff;
            d2_ff  <= v_ff * DATA_W'(a_minus);
         end else begin
            pos_ff <= is_query_ff ? POS_W'(a_minus) : POS_W'(b_ff) + POS_W'(1);
            d1_ff  <= '0 - v_ff;
            d2_ff  <= '0 - (v_ff * DATA_W'(b_ff));
         end
      end
      if (cmd.upd) begin
         if (is_query_ff) begin
            s1_ff  <= s1_ff + rd_data[DATA_W-1:0];
            s2_ff  <= s2_ff + rd_data[WORD_W-1:DATA_W];
            pos_ff <= pos_ff - lowbit;
         end else begin
            pos_ff <= pos_ff + lowbit;
         end
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc) begin
         total_ff <= cmd.phase ? total_ff - diff : diff;
      end
   end

   assign rd_addr = IDX_W'(pos_ff - POS_W'(1));
   assign wr_en   = cmd.clr_step || (cmd.upd && !is_query_ff);
   assign wr_addr = cmd.clr_step ? clr_cnt_ff : rd_addr;
   assign wr_data = cmd.clr_step ? '0 :
                    {rd_data[WORD_W-1:DATA_W] + d2_ff, rd_data[DATA_W-1:0] + d1_ff};

   rars_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_ELEMENTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign status.ok        = ok_ff;
   assign status.is_query  = is_query_ff;
   assign status.pos_valid = (pos_ff != '0) && (pos_ff <= POS_W'(MAX_ELEMENTS));
   assign status.clr_last  = (clr_cnt_ff == IDX_W'(MAX_ELEMENTS - 1));
   assign rsp_range_sum    = total_ff;

endmodule

@@ hw/rtl/rars_ctrl.sv @@
// ----------------------------------------------------------------------------
// rars_ctrl
// Sequencer: clearing pass, tree walks, prefix combine and result strobe.
// ----------------------------------------------------------------------------
module rars_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 csr_wr_en,
   input  rars_pkg::status_type status,
   output rars_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);
   import rars_pkg::*;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_PREP  = 8'b0000_0100,
      S_RD    = 8'b0000_1000,
      S_UPD   = 8'b0001_0000,
      S_MUL   = 8'b0010_0000,
      S_ACC   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.phase = phase_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               phase_in = 1'b0;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (!status.ok) begin
               state_in = status.is_query ? S_OUT : S_IDLE;
            end else begin
               cmd.prep = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (status.pos_valid) begin
               state_in = S_UPD;
            end else if (status.is_query) begin
               state_in = S_MUL;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               state_in = S_PREP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = S_RD;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (!phase_ff) begin
               phase_in = 1'b1;
               state_in = S_PREP;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // a length write empties the array
      if (csr_wr_en) begin
         cmd.clr_start = 1'b1;
         cmd.clr_step  = 1'b0;
         cmd.load      = 1'b0;
         state_in      = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule

@@ hw/rtl/range_add_range_sum_tree.sv @@
// ----------------------------------------------------------------------------
// range_add_range_sum_tree
// Range add / range sum store over up to 1024 signed 32-bit elements.
// ----------------------------------------------------------------------------
// An item is taken when start is high, busy is low and csr_wr_en is low. A
// range add walks two index trees from both range ends and gives no result;
// a query walks two prefix paths and gives one beat on rsp_valid/rsp_range_sum,
// which must be taken in that cycle. Each tree step is a registered RAM read
// followed by a read-modify-write. After reset and after each csr write, busy
// stays high for a clearing pass over all 1024 entries.
module range_add_range_sum_tree (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [rars_pkg::IDX_W-1:0]         req_left_index,
   input  logic [rars_pkg::IDX_W-1:0]         req_right_index,
   input  logic signed [rars_pkg::DATA_W-1:0] req_add_value,
   output logic                               rsp_valid,
   output logic signed [rars_pkg::DATA_W-1:0] rsp_range_sum,
   input  logic                               csr_wr_en,
   input  logic [rars_pkg::LEN_W-1:0]         csr_wr_data
);
   import rars_pkg::*;

   cmd_type    cmd;
   status_type status;

   rars_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .csr_wr_en(csr_wr_en),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   rars_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_type       (req_type),
      .req_left_index (req_left_index),
      .req_right_index(req_right_index),
      .req_add_value  (req_add_value),
      .rsp_range_sum  (rsp_range_sum)
   );

endmodule
